FILE: design/imk_pkg.sv
// imk_pkg: types, codes and the unit-length table for the iambic keyer
// no dependencies; used by imk_step and iambic_morse_keyer_core
`timescale 1ns / 1ps

package imk_pkg;

  typedef enum logic [1:0] {
    EL_NONE = 2'd0,
    EL_DIT  = 2'd1,
    EL_DAH  = 2'd2
  } el_t;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_DIT  = 2'd1,
    REQ_DAH  = 2'd2,
    REQ_BOTH = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DIT_END  = 3'd1,
    EV_DAH_END  = 3'd2,
    EV_CHAR_GAP = 3'd3,
    EV_WORD_SPC = 3'd4
  } ev_t;

  localparam logic [5:0]  WPM_MIN   = 6'd5;
  localparam logic [5:0]  WPM_MAX   = 6'd60;
  localparam logic [5:0]  WPM_RESET = 6'd22;
  localparam logic [9:0]  PHASE_MAX = 10'd1023;
  localparam logic [10:0] IDLE_MAX  = 11'd2047;

  // 1200 / wpm for wpm = 5 .. 60
  localparam logic [7:0] UNIT_TABLE [0:55] = '{
    8'd240, 8'd200, 8'd171, 8'd150, 8'd133, 8'd120, 8'd109, 8'd100,
    8'd92,  8'd85,  8'd80,  8'd75,  8'd70,  8'd66,  8'd63,  8'd60,
    8'd57,  8'd54,  8'd52,  8'd50,  8'd48,  8'd46,  8'd44,  8'd42,
    8'd41,  8'd40,  8'd38,  8'd37,  8'd36,  8'd35,  8'd34,  8'd33,
    8'd32,  8'd31,  8'd30,  8'd30,  8'd29,  8'd28,  8'd27,  8'd27,
    8'd26,  8'd26,  8'd25,  8'd25,  8'd24,  8'd24,  8'd23,  8'd23,
    8'd22,  8'd22,  8'd21,  8'd21,  8'd21,  8'd20,  8'd20,  8'd20
  };

  typedef struct packed {
    logic dit_pressed;
    logic dah_pressed;
  } in_beat_t;

  typedef struct packed {
    logic       key_on;
    logic [2:0] event_res;
  } out_beat_t;

  // lengths derived from the speed register
  typedef struct packed {
    logic [7:0]  unit;
    logic [9:0]  dah_len;
    logic [10:0] char_lim;
    logic [10:0] word_lim;
  } timing_t;

  typedef struct packed {
    el_t         active;
    el_t         previous;
    req_t        pending;
    logic        in_cooldown;
    logic [9:0]  phase;
    logic [10:0] idle;
    logic        char_pending;
    logic        space_sent;
    logic        key_level;
  } state_t;

  function automatic timing_t timing_for(input logic [5:0] wpm);
    logic [5:0]  w;
    logic [7:0]  u;
    logic [10:0] u11;
    timing_t     t;
    if (wpm < WPM_MIN) begin
      w = WPM_MIN;
    end else if (wpm > WPM_MAX) begin
      w = WPM_MAX;
    end else begin
      w = wpm;
    end
    u   = UNIT_TABLE[w - WPM_MIN];
    u11 = {3'b000, u};
    t.unit     = u;
    t.dah_len  = {2'b00, u} + {1'b0, u, 1'b0};
    t.char_lim = (u11 << 2) + u11;
    t.word_lim = (u11 << 3) - u11;
    return t;
  endfunction

endpackage

FILE: design/imk_step.sv
// imk_step: next-state and result logic for one 1 ms tick of the keyer
// depends on imk_pkg
`timescale 1ns / 1ps

module imk_step (
  input  imk_pkg::state_t    cur,
  input  imk_pkg::timing_t   tim,
  input  imk_pkg::in_beat_t  beat,
  output imk_pkg::state_t    nxt,
  output imk_pkg::out_beat_t res
);

  imk_pkg::state_t s;
  imk_pkg::ev_t    ev;
  logic            ended;
  logic [9:0]      len;

  always_comb begin
    s     = cur;
    ev    = imk_pkg::EV_NONE;
    ended = 1'b0;
    len   = (cur.active == imk_pkg::EL_DAH) ? tim.dah_len : {2'b00, tim.unit};

    // running element or cooldown
    if (s.active != imk_pkg::EL_NONE) begin
      if (s.phase < imk_pkg::PHASE_MAX) begin
        s.phase = s.phase + 10'd1;
      end
      if (!s.in_cooldown) begin
        if (s.phase >= len) begin
          s.key_level    = 1'b0;
          ev             = (s.active == imk_pkg::EL_DAH) ? imk_pkg::EV_DAH_END
                                                          : imk_pkg::EV_DIT_END;
          s.in_cooldown  = 1'b1;
          s.phase        = '0;
          s.idle         = '0;
          s.char_pending = 1'b1;
          ended          = 1'b1;
        end
      end else if (s.phase >= {2'b00, tim.unit}) begin
        s.in_cooldown = 1'b0;
        s.phase       = '0;
        s.active      = imk_pkg::EL_NONE;
      end
    end
    if (!ended && s.idle < imk_pkg::IDLE_MAX) begin
      s.idle = s.idle + 11'd1;
    end

    // paddle request latch
    if (beat.dit_pressed && beat.dah_pressed) begin
      s.pending = imk_pkg::REQ_BOTH;
    end else if (beat.dit_pressed) begin
      if (s.active != imk_pkg::EL_DIT) begin
        s.pending = imk_pkg::REQ_DIT;
      end
    end else if (beat.dah_pressed) begin
      if (s.active != imk_pkg::EL_DAH) begin
        s.pending = imk_pkg::REQ_DAH;
      end
    end

    // element start
    if (s.active == imk_pkg::EL_NONE) begin
      priority if (s.pending == imk_pkg::REQ_DIT ||
                   (s.pending == imk_pkg::REQ_BOTH && s.previous == imk_pkg::EL_DAH)) begin
        s.key_level   = 1'b1;
        s.active      = imk_pkg::EL_DIT;
        s.previous    = imk_pkg::EL_DIT;
        s.in_cooldown = 1'b0;
        s.phase       = '0;
        s.space_sent  = 1'b0;
      end else if (s.pending == imk_pkg::REQ_DAH ||
                   (s.pending == imk_pkg::REQ_BOTH && s.previous == imk_pkg::EL_DIT)) begin
        s.key_level   = 1'b1;
        s.active      = imk_pkg::EL_DAH;
        s.previous    = imk_pkg::EL_DAH;
        s.in_cooldown = 1'b0;
        s.phase       = '0;
        s.space_sent  = 1'b0;
      end else begin
        s.active = imk_pkg::EL_NONE;
      end
      s.pending = imk_pkg::REQ_NONE;
    end

    // word space, else character gap
    if (s.active == imk_pkg::EL_NONE) begin
      if (!s.space_sent && s.idle > tim.word_lim) begin
        s.space_sent = 1'b1;
        ev           = imk_pkg::EV_WORD_SPC;
      end else if (s.char_pending && s.idle > tim.char_lim) begin
        s.char_pending = 1'b0;
        ev             = imk_pkg::EV_CHAR_GAP;
      end
    end

    nxt           = s;
    res.key_on    = s.key_level;
    res.event_res = ev;
  end

endmodule

FILE: design/iambic_morse_keyer_core.sv
// iambic_morse_keyer_core: iambic paddle keyer, one result beat per 1 ms tick beat
// depends on imk_pkg and imk_step
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// in_      input      in_valid / in_ready    imk_pkg::in_beat_t  (dit, dah levels)
// out_     output     out_valid / out_ready  imk_pkg::out_beat_t (key_on, event_res)
// cfg_     input      cfg_valid / cfg_ready  6-bit words_per_minute
//
// one tick beat per clock while in_ready; each yields exactly one result next cycle
// the whole tick is evaluated in one pass through imk_step into the result register
// in_ready stays high while the result register is empty or being drained
// cfg_ready is always high; the speed table lookup is registered at the write
// reset (synchronous, active low) loads 22 wpm and an idle keyer

module iambic_morse_keyer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  imk_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output imk_pkg::out_beat_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data
);

  imk_pkg::state_t    state_r;
  imk_pkg::state_t    state_nxt;
  imk_pkg::timing_t   timing_r;
  imk_pkg::out_beat_t out_r;
  imk_pkg::out_beat_t out_nxt;
  logic               out_valid_r;
  logic               in_fire;

  // output register frees up in the same cycle it is drained
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  imk_step u_step (
    .cur  (state_r),
    .tim  (timing_r),
    .beat (in_data),
    .nxt  (state_nxt),
    .res  (out_nxt)
  );

  // speed register: unit, dah length and gap limits precomputed on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r <= imk_pkg::timing_for(imk_pkg::WPM_RESET);
    end else if (cfg_valid && cfg_ready) begin
      timing_r <= imk_pkg::timing_for(cfg_data);
    end
  end

  // keyer state advances once per accepted tick beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.active       <= imk_pkg::EL_NONE;
      state_r.previous     <= imk_pkg::EL_NONE;
      state_r.pending      <= imk_pkg::REQ_NONE;
      state_r.in_cooldown  <= 1'b0;
      state_r.phase        <= '0;
      state_r.idle         <= '0;
      state_r.char_pending <= 1'b0;
      state_r.space_sent   <= 1'b1;
      state_r.key_level    <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  // key is only on inside an element, never during its cooldown
  a_key_in_element: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.key_level |-> (state_r.active != imk_pkg::EL_NONE && !state_r.in_cooldown))
    else $error("key on outside an element");

  // a latched request never survives a tick with no element running
  a_req_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.pending != imk_pkg::REQ_NONE) |-> (state_r.active != imk_pkg::EL_NONE))
    else $error("request left pending while idle");

  // an element-end event always comes with the key dropped
  a_end_key_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.event_res == imk_pkg::EV_DIT_END ||
                     out_r.event_res == imk_pkg::EV_DAH_END)) |-> !out_r.key_on)
    else $error("element end reported with key on");

  // result beat mirrors the key level held in the state
  a_key_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.key_on == state_r.key_level))
    else $error("result key level differs from state");

endmodule
